// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// An overlapping implication: when ante holds, cons must follow as written.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("implication failed");

`endif

// ===== design/svc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svc_pkg
// Constants shared by the swept box velocity clamp and its checker.
// ----------------------------------------------------------------------------
package svc_pkg;
	localparam int COORD_BITS_DEF = 24;
	localparam int DT_BITS        = 16;
	localparam int FRAC_BITS      = 16;
	localparam int RATIO_BITS     = FRAC_BITS + 2;
	localparam int DIV_STAGES     = FRAC_BITS;
	// Front stages, divider stages, ratio, velocity scale, displacement.
	localparam int PIPE_LATENCY   = 3 + DIV_STAGES + 3;
	localparam logic signed [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1 << FRAC_BITS);
endpackage

// ===== design/swept_aabb_velocity_clamp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_aabb_velocity_clamp_core
// Swept box collision: clamps the mover's velocity against a static box.
// ----------------------------------------------------------------------------
// Channel   Signals                         Handshake
// input     dyn_*, stat_*, vel_*, delta_time start high while busy low
// result    new_vel_*, move_*, hit_*        done high for one cycle
//
// One beat enters in every cycle; busy is never raised.
// Each result passes through three front stages,
// sixteen stages of the restoring divider (one quotient bit each), then the
// ratio select, the velocity multiply and the displacement multiply.
// Reset clears only the valid bits; data registers hold no reset.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module swept_aabb_velocity_clamp_core #(
	parameter int COORD_BITS = svc_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_BITS-1:0]        dyn_left,
	input  logic signed [COORD_BITS-1:0]        dyn_top,
	input  logic signed [COORD_BITS-1:0]        dyn_width,
	input  logic signed [COORD_BITS-1:0]        dyn_height,
	input  logic signed [COORD_BITS-1:0]        stat_left,
	input  logic signed [COORD_BITS-1:0]        stat_top,
	input  logic signed [COORD_BITS-1:0]        stat_width,
	input  logic signed [COORD_BITS-1:0]        stat_height,
	input  logic signed [COORD_BITS-1:0]        vel_x,
	input  logic signed [COORD_BITS-1:0]        vel_y,
	input  logic [svc_pkg::DT_BITS-1:0]         delta_time,
	output logic                                done,
	output logic signed [COORD_BITS-1:0]        new_vel_x,
	output logic signed [COORD_BITS-1:0]        new_vel_y,
	output logic signed [COORD_BITS-1:0]        move_x,
	output logic signed [COORD_BITS-1:0]        move_y,
	output logic                                hit_x,
	output logic                                hit_y
);
	localparam int C  = COORD_BITS;
	localparam int E  = C + 1;                     // edge sums
	localparam int G  = C + 2;                     // gap
	localparam int DB = svc_pkg::DT_BITS;
	localparam int P  = C + DB + 1;                // velocity times time
	localparam int FB = svc_pkg::FRAC_BITS;
	localparam int RB = svc_pkg::RATIO_BITS;
	localparam int NS = svc_pkg::DIV_STAGES;

	// The block takes a beat in every cycle.
	assign busy = 1'b0;

	// Axis-indexed views of the inputs: index 0 is horizontal, 1 vertical.
	logic signed [C-1:0] dpos [2];
	logic signed [C-1:0] dsz  [2];
	logic signed [C-1:0] spos [2];
	logic signed [C-1:0] ssz  [2];
	logic signed [C-1:0] vin  [2];

	always_comb begin
		dpos[0] = dyn_left;   dpos[1] = dyn_top;
		dsz[0]  = dyn_width;  dsz[1]  = dyn_height;
		spos[0] = stat_left;  spos[1] = stat_top;
		ssz[0]  = stat_width; ssz[1]  = stat_height;
		vin[0]  = vel_x;      vin[1]  = vel_y;
	end

	// Stage 1: far edges of both boxes and the raw displacement product.
	logic                v_s1;
	logic signed [E-1:0] dpa_s1 [2];
	logic signed [E-1:0] dpb_s1 [2];
	logic signed [E-1:0] spa_s1 [2];
	logic signed [E-1:0] spb_s1 [2];
	logic signed [C-1:0] vel_s1 [2];
	logic signed [P-1:0] prod_s1 [2];
	logic [DB-1:0]       dt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 2; a++) begin
			dpa_s1[a]  <= E'(dpos[a]);
			dpb_s1[a]  <= E'(dpos[a]) + E'(dsz[a]);
			spa_s1[a]  <= E'(spos[a]);
			spb_s1[a]  <= E'(spos[a]) + E'(ssz[a]);
			vel_s1[a]  <= vin[a];
			prod_s1[a] <= P'(vin[a]) * $signed({1'b0, delta_time});
		end
		dt_s1 <= delta_time;
	end

	// Stage 2: leading edge of the mover, facing edge of the static box,
	// the gap between them and the floored displacement.
	logic                v_s2;
	logic signed [G-1:0] gap_s2  [2];
	logic signed [E-1:0] disp_s2 [2];
	logic signed [C-1:0] vel_s2  [2];
	logic [DB-1:0]       dt_s2;

	logic signed [E-1:0] lead_c [2];
	logic signed [E-1:0] face_c [2];

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			logic signed [E-1:0] dlo, dhi, slo, shi;
			dlo = (dpa_s1[a] < dpb_s1[a]) ? dpa_s1[a] : dpb_s1[a];
			dhi = (dpa_s1[a] < dpb_s1[a]) ? dpb_s1[a] : dpa_s1[a];
			slo = (spa_s1[a] < spb_s1[a]) ? spa_s1[a] : spb_s1[a];
			shi = (spa_s1[a] < spb_s1[a]) ? spb_s1[a] : spa_s1[a];
			// Moving forwards leads with the far edge and meets the near one.
			lead_c[a] = vel_s1[a][C-1] ? dlo : dhi;
			face_c[a] = vel_s1[a][C-1] ? shi : slo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 2; a++) begin
			gap_s2[a]  <= G'(face_c[a]) - G'(lead_c[a]);
			disp_s2[a] <= prod_s1[a][P-1:FB];
			vel_s2[a]  <= vel_s1[a];
		end
		dt_s2 <= dt_s1;
	end

	// Stage 3: the hit test. A hit needs the gap and the gap plus the
	// displacement to be of opposite signs, so the gap is always smaller than
	// the displacement and the quotient stays below one. A still axis has no
	// displacement and so can never hit.
	logic                v_s3;
	logic                hit_s3 [2];
	logic [C-1:0]        agap_s3 [2];
	logic [C-1:0]        adisp_s3 [2];
	logic signed [C-1:0] vel_s3 [2];
	logic [DB-1:0]       dt_s3;

	logic                hit_c [2];
	logic signed [G:0]   gap2_c [2];
	logic signed [G-1:0] ngap_c [2];
	logic signed [E-1:0] ndisp_c [2];

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			gap2_c[a]  = (G+1)'(gap_s2[a]) + (G+1)'(disp_s2[a]);
			hit_c[a]   = (gap_s2[a] < 0 && gap2_c[a] > 0) ||
			             (gap_s2[a] > 0 && gap2_c[a] < 0);
			ngap_c[a]  = gap_s2[a][G-1] ? -gap_s2[a] : gap_s2[a];
			ndisp_c[a] = disp_s2[a][E-1] ? -disp_s2[a] : disp_s2[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 2; a++) begin
			hit_s3[a]   <= hit_c[a];
			agap_s3[a]  <= ngap_c[a][C-1:0];
			adisp_s3[a] <= ndisp_c[a][C-1:0];
			vel_s3[a]   <= vel_s2[a];
		end
		dt_s3 <= dt_s2;
	end

	// Divider: restoring division of |gap| * 2^16 by |disp|, one quotient
	// bit per stage. Index 0 is fed from stage 3.
	logic                v_sd   [NS+1];
	logic [C:0]          rem_sd [NS+1][2];
	logic [C-1:0]        dvs_sd [NS+1][2];
	logic [FB-1:0]       quo_sd [NS+1][2];
	logic                hit_sd [NS+1][2];
	logic signed [C-1:0] vel_sd [NS+1][2];
	logic [DB-1:0]       dt_sd  [NS+1];

	always_comb begin
		v_sd[0]  = v_s3;
		dt_sd[0] = dt_s3;
		for (int a = 0; a < 2; a++) begin
			rem_sd[0][a] = {1'b0, agap_s3[a]};
			dvs_sd[0][a] = adisp_s3[a];
			quo_sd[0][a] = '0;
			hit_sd[0][a] = hit_s3[a];
			vel_sd[0][a] = vel_s3[a];
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_div
		logic [C:0] r2 [2];
		logic       ge [2];

		always_comb begin
			for (int a = 0; a < 2; a++) begin
				r2[a] = {rem_sd[k][a][C-1:0], 1'b0};
				ge[a] = r2[a] >= {1'b0, dvs_sd[k][a]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else begin
				v_sd[k+1] <= v_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			for (int a = 0; a < 2; a++) begin
				rem_sd[k+1][a] <= ge[a] ? r2[a] - {1'b0, dvs_sd[k][a]} : r2[a];
				quo_sd[k+1][a] <= {quo_sd[k][a][FB-2:0], ge[a]};
				dvs_sd[k+1][a] <= dvs_sd[k][a];
				hit_sd[k+1][a] <= hit_sd[k][a];
				vel_sd[k+1][a] <= vel_sd[k][a];
			end
			dt_sd[k+1] <= dt_sd[k];
		end
	end

	// Ratio stage. Every hit ratio is minus the quotient, so it is never
	// above one; with both axes hit the more negative one wins.
	logic                 v_sr;
	logic signed [RB-1:0] ratio_sr;
	logic                 hit_sr [2];
	logic signed [C-1:0]  vel_sr [2];
	logic [DB-1:0]        dt_sr;

	logic signed [RB-1:0] rx_c, ry_c, ratio_c;

	always_comb begin
		rx_c = -$signed({2'b00, quo_sd[NS][0]});
		ry_c = -$signed({2'b00, quo_sd[NS][1]});
		priority if (hit_sd[NS][0] && hit_sd[NS][1]) begin
			ratio_c = (rx_c < ry_c) ? rx_c : ry_c;
		end else if (hit_sd[NS][0]) begin
			ratio_c = rx_c;
		end else if (hit_sd[NS][1]) begin
			ratio_c = ry_c;
		end else begin
			ratio_c = svc_pkg::RATIO_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sr <= 1'b0;
		end else begin
			v_sr <= v_sd[NS];
		end
	end

	always_ff @(posedge clk) begin
		ratio_sr <= ratio_c;
		for (int a = 0; a < 2; a++) begin
			hit_sr[a] <= hit_sd[NS][a];
			vel_sr[a] <= vel_sd[NS][a];
		end
		dt_sr <= dt_sd[NS];
	end

	// Velocity scale: floor(vel * ratio / 2^16) on hit axes. The magnitude
	// of the ratio never exceeds one, so the result stays in range.
	logic                  v_sv;
	logic signed [C-1:0]   nv_sv  [2];
	logic                  hit_sv [2];
	logic [DB-1:0]         dt_sv;
	logic signed [C+RB-1:0] vr_c  [2];

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			vr_c[a] = (C+RB)'(vel_sr[a]) * (C+RB)'(ratio_sr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sv <= 1'b0;
		end else begin
			v_sv <= v_sr;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 2; a++) begin
			nv_sv[a]  <= hit_sr[a] ? vr_c[a][FB+C-1:FB] : vel_sr[a];
			hit_sv[a] <= hit_sr[a];
		end
		dt_sv <= dt_sr;
	end

	// Displacement: floor(new_vel * time / 2^16). The time is below one, so
	// the result always fits and needs no saturation.
	logic signed [P-1:0] mv_c [2];

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			mv_c[a] = P'(nv_sv[a]) * $signed({1'b0, dt_sv});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_sv;
		end
	end

	always_ff @(posedge clk) begin
		new_vel_x <= nv_sv[0];
		new_vel_y <= nv_sv[1];
		move_x    <= mv_c[0][FB+C-1:FB];
		move_y    <= mv_c[1][FB+C-1:FB];
		hit_x     <= hit_sv[0];
		hit_y     <= hit_sv[1];
	end
endmodule

// ===== design/svc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svc_checker
// Port-level checks on the swept box velocity clamp, bound to its core module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svc_checker #(
	parameter int COORD_BITS = svc_pkg::COORD_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic signed [COORD_BITS-1:0] vel_x,
	input logic signed [COORD_BITS-1:0] vel_y,
	input logic                         done,
	input logic signed [COORD_BITS-1:0] new_vel_x,
	input logic signed [COORD_BITS-1:0] new_vel_y,
	input logic                         hit_x,
	input logic                         hit_y
);
	localparam int LAT = svc_pkg::PIPE_LATENCY;

	// The pipeline never refuses a beat.
	`ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy)
	// Every accepted beat gives its result after the fixed latency.
	`ASSERT_IMPL(a_result_follows, clk, arst_n, start, ##LAT done)
	// No result appears without a beat behind it.
	`ASSERT_IMPL(a_no_spurious, clk, arst_n, !start, ##LAT !done)
	// Without a hit both velocities pass unchanged.
	`ASSERT_IMPL(a_no_hit_pass, clk, arst_n, done && !hit_x && !hit_y,
		(new_vel_x == $past(vel_x, LAT) && new_vel_y == $past(vel_y, LAT)))
endmodule

bind swept_aabb_velocity_clamp_core svc_checker #(.COORD_BITS(COORD_BITS)) u_svc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.vel_x     (vel_x),
	.vel_y     (vel_y),
	.done      (done),
	.new_vel_x (new_vel_x),
	.new_vel_y (new_vel_y),
	.hit_x     (hit_x),
	.hit_y     (hit_y)
);
